>>> src/rcfd_pkg.sv
// Package for the RC channel frame decoder: phase codes, frame constants,
// register indexes and the command/status structs between controller and datapath.
// Used by rcfd_ctrl, rcfd_datapath and rc_channel_frame_decoder_core.
package rcfd_pkg;

   localparam int CHANNEL_COUNT    = 16;
   localparam int MAX_FRAME_LENGTH = 62;
   localparam int PAYLOAD_BYTES    = 22;
   localparam int RAW_WIDTH        = 11;
   localparam int PAYLOAD_WIDTH    = PAYLOAD_BYTES * 8;

   localparam logic [7:0]  SYNC_BYTE     = 8'hC8;
   localparam logic [7:0]  RC_TYPE       = 8'h16;
   localparam logic [5:0]  RC_MIN_LENGTH = 6'd23;
   localparam logic [11:0] RAW_CENTRE    = 12'd992;
   localparam logic [10:0] FULL_SCALE    = 11'd819;
   localparam logic [14:0] AXIS_ONE      = 15'd16384;

   localparam logic CSR_SWITCH_THRESHOLD = 1'b0;
   localparam logic CSR_BUTTON_MASK      = 1'b1;

   localparam logic [14:0] THRESHOLD_RESET = 15'd8192;
   localparam logic [15:0] MASK_RESET      = 16'hFFF0;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LENGTH,
      PH_BODY,
      PH_EMIT
   } phase_type;

   typedef struct packed {
      logic load_length;
      logic store_byte;
      logic issue;
   } ctl_cmd_type;

   typedef struct packed {
      logic sync_seen;
      logic length_ok;
      logic frame_end;
      logic rc_frame;
      logic issue_free;
      logic issue_last;
   } ctl_status_type;

endpackage

>>> src/rc_channel_frame_decoder_core.sv
// Top level of the RC channel frame decoder: joins the parsing controller and
// the datapath. Depends on rcfd_pkg, rcfd_ctrl and rcfd_datapath.
//
//   Port group   Direction   Carries
//   req_         in          one received byte per transfer
//   rsp_         out         one decoded channel per transfer, sixteen per RC frame
//   csr_         in          switch threshold (index 0) and button mask (index 1)
//
// Bytes are taken one per cycle while hunting, reading the length and collecting
// the frame body. When a valid RC frame ends, req_stall is held high while the
// sixteen channels are issued from the payload shift store, one per cycle while
// rsp_stall does not hold the two-stage output pipeline.
// The last channels drain through that pipeline while new bytes are taken.
// Reset is synchronous: the parser hunts for sync, threshold 8192, mask 0xFFF0.
module rc_channel_frame_decoder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_byte_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_channel_index,
   output logic [10:0]        rsp_raw_value,
   output logic signed [15:0] rsp_axis_value,
   output logic               rsp_is_button,
   output logic               rsp_pressed,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [15:0]        csr_write_data
);

   rcfd_pkg::ctl_cmd_type    cmd;
   rcfd_pkg::ctl_status_type status;

   rcfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rcfd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_byte_value    (req_byte_value),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_raw_value     (rsp_raw_value),
      .rsp_axis_value    (rsp_axis_value),
      .rsp_is_button     (rsp_is_button),
      .rsp_pressed       (rsp_pressed),
      .rsp_last          (rsp_last)
   );

endmodule

>>> src/rcfd_ctrl.sv
// Frame parsing controller: hunts for sync, takes the length, counts the body
// and sequences the channel issue. Depends on rcfd_pkg.
module rcfd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rcfd_pkg::ctl_status_type status,
   output rcfd_pkg::ctl_cmd_type    cmd
);

   rcfd_pkg::phase_type phase_ff;
   rcfd_pkg::phase_type phase_in;
   logic                accepted;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rcfd_pkg::PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      req_stall       = (phase_ff == rcfd_pkg::PH_EMIT);
      accepted        = req_valid && !req_stall;
      cmd.load_length = 1'b0;
      cmd.store_byte  = 1'b0;
      cmd.issue       = 1'b0;
      phase_in        = phase_ff;
      case (phase_ff)
         rcfd_pkg::PH_HUNT: begin
            if (accepted && status.sync_seen) begin
               phase_in = rcfd_pkg::PH_LENGTH;
            end
         end
         rcfd_pkg::PH_LENGTH: begin
            if (accepted) begin
               if (status.length_ok) begin
                  cmd.load_length = 1'b1;
                  phase_in        = rcfd_pkg::PH_BODY;
               end else begin
                  phase_in = rcfd_pkg::PH_HUNT;
               end
            end
         end
         rcfd_pkg::PH_BODY: begin
            if (accepted) begin
               cmd.store_byte = 1'b1;
               if (status.frame_end) begin
                  phase_in = status.rc_frame ? rcfd_pkg::PH_EMIT : rcfd_pkg::PH_HUNT;
               end
            end
         end
         rcfd_pkg::PH_EMIT: begin
            cmd.issue = 1'b1;
            // The last channel leaves for the pipeline in this cycle.
            if (status.issue_free && status.issue_last) begin
               phase_in = rcfd_pkg::PH_HUNT;
            end
         end
         default: begin
            phase_in = rcfd_pkg::PH_HUNT;
         end
      endcase
   end

endmodule

>>> src/rcfd_datapath.sv
// Datapath: length and byte counters, payload shift store, configuration
// registers and the two-stage channel scaling pipeline. Depends on rcfd_pkg.
module rcfd_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_byte_value,
   input  rcfd_pkg::ctl_cmd_type    cmd,
   output rcfd_pkg::ctl_status_type status,
   input  logic                    csr_write_enable,
   input  logic                    csr_index,
   input  logic [15:0]             csr_write_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [3:0]              rsp_channel_index,
   output logic [10:0]             rsp_raw_value,
   output logic signed [15:0]      rsp_axis_value,
   output logic                    rsp_is_button,
   output logic                    rsp_pressed,
   output logic                    rsp_last
);

   logic [5:0]                          length_ff;
   logic [5:0]                          count_ff;
   logic [5:0]                          count_next;
   logic [7:0]                          type_ff;
   logic [7:0]                          type_now;
   logic [rcfd_pkg::PAYLOAD_WIDTH-1:0]  payload_ff;
   logic [14:0]                         threshold_ff;
   logic [15:0]                         mask_ff;
   logic [3:0]                          channel_ff;

   // Stage A: channel offset from centre as sign and magnitude.
   logic                                a_valid_ff;
   logic [3:0]                          a_channel_ff;
   logic [10:0]                         a_raw_ff;
   logic                                a_neg_ff;
   logic [10:0]                         a_mag_ff;
   logic                                a_button_ff;

   logic                                out_valid_ff;
   logic [3:0]                          out_channel_ff;
   logic [10:0]                         out_raw_ff;
   logic signed [15:0]                  out_axis_ff;
   logic                                out_button_ff;
   logic                                out_pressed_ff;
   logic                                out_last_ff;

   logic                                out_load;
   logic                                a_free;
   logic                                issue_fire;
   logic [10:0]                         raw_now;
   logic [11:0]                         offset;
   logic [10:0]                         mag_now;
   logic [12:0]                         round_term;
   logic [2:0]                          frac;
   logic [14:0]                         quotient;
   logic signed [15:0]                  axis_now;

   assign count_next = count_ff + 6'd1;
   assign type_now   = (count_ff == 6'd0) ? req_byte_value : type_ff;

   always_comb begin
      status.sync_seen  = (req_byte_value == rcfd_pkg::SYNC_BYTE);
      status.length_ok  = (req_byte_value != 8'd0) &&
                          (req_byte_value <= 8'(rcfd_pkg::MAX_FRAME_LENGTH));
      status.frame_end  = (count_next >= length_ff);
      status.rc_frame   = (type_now == rcfd_pkg::RC_TYPE) &&
                          (length_ff >= rcfd_pkg::RC_MIN_LENGTH);
      status.issue_free = a_free;
      status.issue_last = (channel_ff == 4'(rcfd_pkg::CHANNEL_COUNT - 1));
   end

   assign out_load   = !out_valid_ff || !rsp_stall;
   assign a_free     = !a_valid_ff || out_load;
   assign issue_fire = cmd.issue && a_free;

   // Frame bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= 6'd0;
         count_ff  <= 6'd0;
         type_ff   <= 8'd0;
      end else if (cmd.load_length) begin
         length_ff <= req_byte_value[5:0];
         count_ff  <= 6'd0;
      end else if (cmd.store_byte) begin
         count_ff <= count_next;
         if (count_ff == 6'd0) begin
            type_ff <= req_byte_value;
         end
      end
   end

   // Payload bytes land in their own lane; during the issue the store shifts
   // down one channel per transfer into stage A.
   always_ff @(posedge clock) begin
      if (issue_fire) begin
         payload_ff <= {{rcfd_pkg::RAW_WIDTH{1'b0}},
                        payload_ff[rcfd_pkg::PAYLOAD_WIDTH-1:rcfd_pkg::RAW_WIDTH]};
      end else if (cmd.store_byte) begin
         for (int k = 0; k < rcfd_pkg::PAYLOAD_BYTES; k++) begin
            if (count_ff == 6'(k + 1)) begin
               payload_ff[8*k +: 8] <= req_byte_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= rcfd_pkg::THRESHOLD_RESET;
         mask_ff      <= rcfd_pkg::MASK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rcfd_pkg::CSR_SWITCH_THRESHOLD: threshold_ff <= csr_write_data[14:0];
            rcfd_pkg::CSR_BUTTON_MASK:      mask_ff      <= csr_write_data;
            default:                        mask_ff      <= mask_ff;
         endcase
      end
   end

   assign raw_now = payload_ff[rcfd_pkg::RAW_WIDTH-1:0];
   assign offset  = {1'b0, raw_now} - rcfd_pkg::RAW_CENTRE;
   assign mag_now = offset[11] ? 11'(-offset) : offset[10:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= 4'd0;
         a_valid_ff <= 1'b0;
      end else begin
         if (issue_fire) begin
            channel_ff <= channel_ff + 4'd1;
         end
         if (a_free) begin
            a_valid_ff <= issue_fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue_fire) begin
         a_channel_ff <= channel_ff;
         a_raw_ff     <= raw_now;
         a_neg_ff     <= offset[11];
         a_mag_ff     <= mag_now;
         a_button_ff  <= mask_ff[channel_ff];
      end
   end

   // 16384/819 is 20 + 4/819, so the rounded quotient is 20*mag plus a small
   // correction that a few compares give; offsets of 819 and more clamp to one.
   always_comb begin
      round_term = {a_mag_ff, 2'b00} + 13'd409;
      if (round_term >= 13'd3276) begin
         frac = 3'd4;
      end else if (round_term >= 13'd2457) begin
         frac = 3'd3;
      end else if (round_term >= 13'd1638) begin
         frac = 3'd2;
      end else if (round_term >= 13'd819) begin
         frac = 3'd1;
      end else begin
         frac = 3'd0;
      end
      if (a_mag_ff >= rcfd_pkg::FULL_SCALE) begin
         quotient = rcfd_pkg::AXIS_ONE;
      end else begin
         quotient = {1'b0, a_mag_ff[9:0], 4'b0000} + {3'b000, a_mag_ff[9:0], 2'b00}
                    + {12'd0, frac};
      end
      axis_now = a_neg_ff ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && a_valid_ff) begin
         out_channel_ff <= a_channel_ff;
         out_raw_ff     <= a_raw_ff;
         out_axis_ff    <= axis_now;
         out_button_ff  <= a_button_ff;
         out_pressed_ff <= a_button_ff &&
                           (axis_now > $signed({threshold_ff[14], threshold_ff}));
         out_last_ff    <= (a_channel_ff == 4'(rcfd_pkg::CHANNEL_COUNT - 1));
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_channel_index = out_channel_ff;
   assign rsp_raw_value     = out_raw_ff;
   assign rsp_axis_value    = out_axis_ff;
   assign rsp_is_button     = out_button_ff;
   assign rsp_pressed       = out_pressed_ff;
   assign rsp_last          = out_last_ff;

endmodule
